/* design/permutation_unrank_macros.svh */
// Assertion helpers used by the checker file.
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// Clocked check, off while reset is asserted.
`define PU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("permutation_unrank: check failed");

// Clocked check that also holds during reset.
`define PU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("permutation_unrank: check failed");

`endif

/* design/pu_pkg.sv */
package pu_pkg;

  localparam int SizeW  = 5;
  localparam int RankW  = 45;
  localparam int ElemW  = 5;
  localparam int PosW   = 4;
  localparam int FactW  = 64;
  localparam int QW     = 5;
  localparam int CntW   = 3;
  localparam int CmdDepth = 2;
  localparam int ResDepth = 2;

  typedef struct packed {
    logic [SizeW-1:0] set_size;
    logic [RankW-1:0] rank;
  } pu_item_t;

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic [PosW-1:0]  position;
    logic             last;
    logic             error;
  } pu_result_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic             err;
    logic [SizeW-1:0] size;
    logic [RankW-1:0] rem;
  } pu_cmd_t;

  typedef enum logic [1:0] {
    PuIdle,
    PuDiv,
    PuEmit
  } pu_state_e;

  function automatic logic [FactW-1:0] fact(input logic [SizeW-1:0] m);
    logic [FactW-1:0] f;
    case (m)
      5'd0:    f = 64'd1;
      5'd1:    f = 64'd1;
      5'd2:    f = 64'd2;
      5'd3:    f = 64'd6;
      5'd4:    f = 64'd24;
      5'd5:    f = 64'd120;
      5'd6:    f = 64'd720;
      5'd7:    f = 64'd5040;
      5'd8:    f = 64'd40320;
      5'd9:    f = 64'd362880;
      5'd10:   f = 64'd3628800;
      5'd11:   f = 64'd39916800;
      5'd12:   f = 64'd479001600;
      5'd13:   f = 64'd6227020800;
      5'd14:   f = 64'd87178291200;
      5'd15:   f = 64'd1307674368000;
      5'd16:   f = 64'd20922789888000;
      5'd17:   f = 64'd355687428096000;
      5'd18:   f = 64'd6402373705728000;
      5'd19:   f = 64'd121645100408832000;
      5'd20:   f = 64'd2432902008176640000;
      default: f = '0;
    endcase
    return f;
  endfunction

  // quotient bits needed when dividing by m! (quotient never exceeds m)
  function automatic logic [CntW-1:0] qbits(input logic [SizeW-1:0] m);
    logic [CntW-1:0] b;
    case (m) inside
      5'd0:           b = 3'd0;
      5'd1:           b = 3'd1;
      [5'd2:5'd3]:    b = 3'd2;
      [5'd4:5'd7]:    b = 3'd3;
      [5'd8:5'd15]:   b = 3'd4;
      default:        b = 3'd5;
    endcase
    return b;
  endfunction

endpackage

/* design/pu_fifo.sv */
module pu_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/pu_front.sv */
module pu_front #(
  parameter int MAX_N = 16
) (
  input  pu_pkg::pu_item_t item_i,
  output pu_pkg::pu_cmd_t  cmd_o
);
  import pu_pkg::*;

  logic             size_ok;
  logic             rank_ok;
  logic [FactW-1:0] limit;

  always_comb begin
    size_ok = (item_i.set_size != '0) && (item_i.set_size <= SizeW'(MAX_N));
    // sizes past the table give a zero limit, so the rank check fails too
    limit   = fact(item_i.set_size);
    rank_ok = (item_i.rank != '0) && (FactW'(item_i.rank) <= limit);
    cmd_o.err  = !(size_ok && rank_ok);
    cmd_o.size = item_i.set_size;
    cmd_o.rem  = item_i.rank - RankW'(1);
  end

endmodule

/* design/pu_back.sv */
module pu_back #(
  parameter int MAX_N = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pu_pkg::pu_cmd_t     cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output pu_pkg::pu_result_t  res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);
  import pu_pkg::*;

  pu_state_e        state_q, state_d;
  logic             err_q, err_d;
  logic [RankW-1:0] rem_q, rem_d;
  logic [FactW-1:0] div_q, div_d;
  logic [QW-1:0]    q_q, q_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] m_q, m_d;
  logic [SizeW-1:0] p_q, p_d;
  logic [ElemW-1:0] list_q [MAX_N];
  logic [ElemW-1:0] list_d [MAX_N];

  logic             load;
  logic [SizeW-1:0] m_nx;
  logic [CntW-1:0]  qb;
  logic [FactW-1:0] fm;
  logic             ge;
  logic [ElemW-1:0] sel;

  // list_q holds the unused values in ascending order; q picks one
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_N; i++) begin
      if (QW'(i) == q_q) begin
        sel = sel | list_q[i];
      end
    end
  end

  always_comb begin
    res_o.element  = err_q ? '0 : sel;
    res_o.position = err_q ? '0 : p_q[PosW-1:0];
    res_o.last     = err_q || (m_q == '0);
    res_o.error    = err_q;
  end

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    rem_d      = rem_q;
    div_d      = div_q;
    q_d        = q_q;
    cnt_d      = cnt_q;
    m_d        = m_q;
    p_d        = p_q;
    list_d     = list_q;
    load       = 1'b0;
    m_nx       = m_q;
    qb         = '0;
    fm         = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    ge         = ({{(FactW-RankW){1'b0}}, rem_q} >= div_q);

    case (state_q)
      PuIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          err_d     = cmd_i.err;
          rem_d     = cmd_i.rem;
          p_d       = '0;
          q_d       = '0;
          m_d       = '0;
          for (int i = 0; i < MAX_N; i++) begin
            list_d[i] = ElemW'(i + 1);
          end
          if (cmd_i.err) begin
            state_d = PuEmit;
          end else begin
            m_nx = cmd_i.size - SizeW'(1);
            load = 1'b1;
          end
        end
      end
      PuDiv: begin
        // restoring division, one quotient bit per cycle
        if (ge) begin
          rem_d = rem_q - div_q[RankW-1:0];
        end
        q_d   = {q_q[QW-2:0], ge};
        div_d = div_q >> 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = PuEmit;
        end
      end
      PuEmit: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (err_q || (m_q == '0)) begin
            state_d = PuIdle;
          end else begin
            for (int i = 0; i < MAX_N - 1; i++) begin
              if (QW'(i) >= q_q) begin
                list_d[i] = list_q[i+1];
              end
            end
            p_d  = p_q + SizeW'(1);
            m_nx = m_q - SizeW'(1);
            load = 1'b1;
          end
        end
      end
      default: state_d = PuIdle;
    endcase

    // set up the divisor (m)! aligned to the top quotient bit
    if (load) begin
      qb    = qbits(m_nx);
      fm    = fact(m_nx);
      m_d   = m_nx;
      q_d   = '0;
      cnt_d = qb;
      div_d = (qb == '0) ? fm : (fm << (qb - CntW'(1)));
      state_d = (qb == '0) ? PuEmit : PuDiv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PuIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    q_q    <= q_d;
    cnt_q  <= cnt_d;
    m_q    <= m_d;
    p_q    <= p_d;
    list_q <= list_d;
  end

endmodule

/* design/permutation_unrank.sv */
// Channel   Handshake            Payload     Beat
// ------    ---------            -------     ----
// input     push / full          item_i      one (set_size, rank) request
// result    empty / pop          result_o    one element of the permutation
//
// In the back end an item is taken in the idle state; each position then divides
// by (n-1-p)! one quotient bit at a time and emits; an error item just emits.
// The rate is set by the restoring divider, one quotient bit per cycle.
// The front classifies in the accept cycle; a 2-deep queue decouples it.
// Reset empties both queues and idles the back end; no clearing pass.
// A full result queue stalls the back end in its emit state.
module permutation_unrank #(
  parameter int MAX_N = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pu_pkg::pu_item_t   item_i,
  output logic               empty,
  input  logic               pop,
  output pu_pkg::pu_result_t result_o
);
  import pu_pkg::*;

  pu_cmd_t    cmd_in, cmd_out;
  logic       cmd_empty, cmd_pop;
  pu_result_t res_in;
  logic       res_push, res_full;

  pu_front #(.MAX_N(MAX_N)) u_front (
    .item_i (item_i),
    .cmd_o  (cmd_in)
  );

  pu_fifo #(.Width($bits(pu_cmd_t)), .Depth(CmdDepth)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  pu_back #(.MAX_N(MAX_N)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  pu_fifo #(.Width($bits(pu_result_t)), .Depth(ResDepth)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

/* design/pu_checker.sv */
`include "permutation_unrank_macros.svh"

module pu_checker #(
  parameter int MAX_N = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input pu_pkg::pu_result_t result_o
);
  import pu_pkg::*;

  logic err_clean;
  logic elem_ok;

  assign err_clean = result_o.last && (result_o.element == '0) && (result_o.position == '0);
  assign elem_ok   = (result_o.element != '0) && (result_o.element <= ElemW'(MAX_N));

  // an error beat stands alone: last set, no element, position zero
  `PU_ASSERT_ALWAYS(a_err_shape, !empty && result_o.error |-> err_clean)

  // a regular beat carries a value of the permuted set
  `PU_ASSERT_ALWAYS(a_elem_range, !empty && !result_o.error |-> elem_ok)

  // a beat not taken stays on the result ports
  `PU_ASSERT(a_res_hold, !empty && !pop |=> !empty && $stable(result_o))

  // the input queue fills only through an accepted beat
  `PU_ASSERT(a_full_cause, !full && !push |=> !full)

endmodule

bind permutation_unrank pu_checker #(.MAX_N(MAX_N)) u_pu_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

/* bench/permutation_unrank_tb.sv */
`timescale 1ns / 100ps

module permutation_unrank_tb;
  import pu_pkg::*;

  localparam int MaxN = 16;
  localparam int QuietTail = 60;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push   = 1'b0;
  logic       full;
  pu_item_t   item_i = '0;
  logic       empty;
  logic       pop    = 1'b0;
  pu_result_t result_o;

  pu_item_t   req_q[$];
  pu_result_t perm_expected[$];

  int total_reqs = 1 << 30;
  int drain_a    = -1;
  int drain_b    = -1;
  int sent       = 0;
  int popped     = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int mismatches = 0;
  int bad_reqs   = 0;
  int good_reqs  = 0;

  permutation_unrank #(
    .MAX_N(MaxN)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned factorial(input int m);
    longint unsigned f;
    f = 1;
    for (int i = 2; i <= m; i++) f = f * longint'(i);
    return f;
  endfunction

  // Expected element run for one request, in position order.
  task automatic unrank_perm(input pu_item_t req);
    longint unsigned r;
    longint unsigned f;
    longint unsigned q;
    int              n;
    logic [MaxN:0]   taken;
    logic [4:0]      elem;
    logic            found;
    pu_result_t      res;
    n = req.set_size;
    if (n == 0 || n > MaxN || req.rank == 0 || req.rank > factorial(n)) begin
      res = '{element: '0, position: '0, last: 1'b1, error: 1'b1};
      perm_expected.push_back(res);
      bad_reqs++;
      return;
    end
    good_reqs++;
    r = req.rank - 1;
    taken = '0;
    for (int p = 0; p < n; p++) begin
      f = factorial(n - 1 - p);
      q = r / f;
      r = r % f;
      elem = '0;
      found = 1'b0;
      for (int v = 1; v <= n; v++) begin
        if (!found && !taken[v]) begin
          if (q == 0) begin
            elem = v[4:0];
            taken[v] = 1'b1;
            found = 1'b1;
          end else begin
            q--;
          end
        end
      end
      res = '{element: elem, position: p[3:0], last: (p == n - 1), error: 1'b0};
      perm_expected.push_back(res);
    end
  endtask

  task automatic queue_req(input int n, input longint unsigned k);
    pu_item_t req;
    req.set_size = n[4:0];
    req.rank     = k[44:0];
    req_q.push_back(req);
  endtask

  // Sender: holds a beat until accepted, random idle bursts, drains at two points.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        unrank_perm(item_i);
        sent++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (req_q.size() == 0 ||
                     ((sent == drain_a || sent == drain_b) && perm_expected.size() != 0)) begin
          push <= 1'b0;
        end else if (sent < total_reqs - QuietTail && ((sent / 40) % 3) != 2 &&
                     $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 5);
          push <= 1'b0;
        end else begin
          item_i <= req_q.pop_front();
          push   <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stall bursts, checks each beat against the oldest expectation.
  always @(posedge clk_i) begin
    pu_result_t exp_res;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        popped++;
        if (perm_expected.size() == 0) begin
          $error("unexpected beat: element %0d position %0d last %0b error %0b",
                 result_o.element, result_o.position, result_o.last, result_o.error);
          mismatches++;
        end else begin
          exp_res = perm_expected.pop_front();
          if (result_o.element !== exp_res.element) begin
            $error("element: expected %0d, got %0d", exp_res.element, result_o.element);
            mismatches++;
          end
          if (result_o.position !== exp_res.position) begin
            $error("position: expected %0d, got %0d", exp_res.position, result_o.position);
            mismatches++;
          end
          if (result_o.last !== exp_res.last) begin
            $error("last: expected %0b, got %0b", exp_res.last, result_o.last);
            mismatches++;
          end
          if (result_o.error !== exp_res.error) begin
            $error("error: expected %0b, got %0b", exp_res.error, result_o.error);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (sent < total_reqs - QuietTail && ((popped / 90) % 3) != 2 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int              n;
    int              sel;
    longint unsigned k;
    longint unsigned wide;

    // Directed: size and rank edges, single element, largest set.
    queue_req(0, 1);
    queue_req(17, 1);
    queue_req(31, 64'h1FFF_FFFF_FFFF);
    queue_req(1, 1);
    queue_req(1, 0);
    queue_req(1, 2);
    queue_req(2, 1);
    queue_req(2, 2);
    queue_req(3, 4);
    queue_req(4, 24);
    queue_req(4, 25);
    queue_req(5, 0);
    queue_req(6, 1);
    queue_req(8, 20000);
    queue_req(15, factorial(15));
    queue_req(16, 1);
    queue_req(16, factorial(16));
    queue_req(16, factorial(16) + 1);
    queue_req(16, 64'h1FFF_FFFF_FFFF);
    queue_req(16, factorial(16) / 2 + 7);
    drain_a = req_q.size();

    for (int i = 0; i < 430; i++) begin
      sel = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (sel < 80) begin
        n = (sel < 60) ? $urandom_range(1, 7) : $urandom_range(1, MaxN);
        k = wide % factorial(n) + 1;
      end else if (sel < 90) begin
        // valid size, rank just past the end, zero, or anywhere in 45 bits
        n = $urandom_range(1, MaxN);
        case ($urandom_range(0, 2))
          0:       k = factorial(n) + 1 + $urandom_range(0, 3);
          1:       k = 0;
          default: k = wide & 64'h1FFF_FFFF_FFFF;
        endcase
      end else begin
        n = $urandom_range(0, 31);
        k = wide & 64'h1FFF_FFFF_FFFF;
      end
      queue_req(n, k);
    end
    drain_b = drain_a + 200;
    total_reqs = req_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent < total_reqs) @(posedge clk_i);
    while (perm_expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d requests: %0d valid permutations, %0d out of range",
             total_reqs, good_reqs, bad_reqs);
    $display("Checked %0d result beats, %0d field mismatches", popped, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout: %0d of %0d requests sent, %0d beats outstanding",
           sent, total_reqs, perm_expected.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/pu_pkg.sv
design/pu_fifo.sv
design/pu_front.sv
design/pu_back.sv
design/permutation_unrank.sv
design/pu_checker.sv
bench/permutation_unrank_tb.sv
